// ----- rtl/core/tpid_pkg.sv -----
// Shared types and constants for the thermocouple PID heater drive.
package tpid_pkg;

  localparam int MulSteps = 13;
  localparam int DivSteps = 27;

  localparam logic [4:0] MulLast = 5'(MulSteps - 1);
  localparam logic [4:0] DivLast = 5'(DivSteps - 1);

  localparam logic [16:0] GainDivisor = 17'd400;
  localparam logic [12:0] IntScale    = 13'd400;
  localparam logic [15:0] ErrorOffset = 16'd12;
  localparam logic [7:0]  DutyOff     = 8'd255;
  localparam logic [26:0] IntMaxMag   = 27'd32767;
  localparam logic [26:0] IntMinMag   = 27'd32768;
  localparam logic [15:0] IntMax      = 16'h7fff;
  localparam logic [15:0] IntMin      = 16'h8000;

  localparam logic [13:0] SetpointRst = 14'd0;
  localparam logic [9:0]  GainPRst    = 10'd90;
  localparam logic [9:0]  GainIRst    = 10'd30;
  localparam logic [9:0]  GainDRst    = 10'd80;

  typedef enum logic [1:0] {
    REG_SETPOINT,
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D
  } tpid_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_MUL,
    ST_P_ABS,
    ST_P_DIV,
    ST_P_SUM,
    ST_I_MUL0,
    ST_I_MUL1,
    ST_I_ABS,
    ST_I_DIV,
    ST_I_SUM,
    ST_D_MUL,
    ST_D_ABS,
    ST_D_DIV,
    ST_D_SUM,
    ST_DONE
  } tpid_state_e;

  typedef struct packed {
    logic in_stall;
    logic mul_en;
    logic abs_en;
    logic div_en;
  } tpid_ctl_t;

endpackage

// ----- rtl/core/thermocouple_pid_heater_drive.sv -----
// PID heater drive from raw thermocouple words, with serial multiplier and divider.
// Each of P, I and D uses the multiplier and divider; D is skipped when elapsed_ms is zero,
//   and an open-thermocouple word goes straight to ST_DONE.
// One transaction at a time: input is stalled until the result is registered. The shared
//   multiplier is a 13-step shift-add (twice for I), the divider a 27-step restoring one.
// Reset: configuration registers return to their reset values, integrator and last error clear to zero.
module thermocouple_pid_heater_drive (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] raw_word_i,
  input  logic [15:0] elapsed_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  pwm_duty_o,
  output logic        sensor_fault_o,
  output logic [12:0] temperature_quarter_deg_o
);

  tpid_pkg::tpid_state_e state_q, state_d;
  tpid_pkg::tpid_ctl_t   ctl;

  logic [13:0] setpoint_q;
  logic [9:0]  gain_p_q, gain_i_q, gain_d_q;
  logic        cfg_wr;

  logic [4:0]  cnt_q, cnt_d;
  logic        mul_last, div_last;
  logic [31:0] acc_q, mcand_q;
  logic [12:0] mplier_q;
  logic        neg_q;
  logic [26:0] quo_q;
  logic [16:0] rem_q;
  logic [16:0] dvs_q;
  logic [29:0] sum_q;
  logic [15:0] e_q, integ_q, last_err_q, ms_q;
  logic [12:0] temp_q;
  logic        fault_q;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  pwm_duty_q;
  logic        sensor_fault_q;
  logic [12:0] temp_out_q;
  logic        out_free;

  logic [15:0] e_in;
  logic [31:0] acc_step, acc_mag;
  logic [17:0] rem_sh;
  logic [18:0] trial;
  logic        q_bit;
  logic [16:0] rem_next;
  logic [26:0] quo_next;
  logic [29:0] q_ext, sum_add, sum_i;
  logic [15:0] i_sat;
  logic [16:0] diff_err;
  logic [12:0] gd5;
  logic [7:0]  sum_clamp;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= tpid_pkg::SetpointRst;
      gain_p_q   <= tpid_pkg::GainPRst;
      gain_i_q   <= tpid_pkg::GainIRst;
      gain_d_q   <= tpid_pkg::GainDRst;
    end else if (cfg_wr) begin
      case (tpid_pkg::tpid_reg_e'(paddr[3:2]))
        tpid_pkg::REG_SETPOINT: setpoint_q <= pwdata[13:0];
        tpid_pkg::REG_GAIN_P:   gain_p_q   <= pwdata[9:0];
        tpid_pkg::REG_GAIN_I:   gain_i_q   <= pwdata[9:0];
        tpid_pkg::REG_GAIN_D:   gain_d_q   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (tpid_pkg::tpid_reg_e'(paddr[3:2]))
      tpid_pkg::REG_SETPOINT: prdata = {{18{setpoint_q[13]}}, setpoint_q};
      tpid_pkg::REG_GAIN_P:   prdata = {22'd0, gain_p_q};
      tpid_pkg::REG_GAIN_I:   prdata = {22'd0, gain_i_q};
      tpid_pkg::REG_GAIN_D:   prdata = {22'd0, gain_d_q};
      default:                prdata = 32'd0;
    endcase
  end

  // Datapath arithmetic
  assign e_in = {{2{setpoint_q[13]}}, setpoint_q} - {3'b000, raw_word_i[15:3]}
              + tpid_pkg::ErrorOffset;

  assign acc_step = acc_q + (mplier_q[0] ? mcand_q : 32'd0);
  assign acc_mag  = acc_q[31] ? (32'd0 - acc_q) : acc_q;

  assign rem_sh   = {rem_q, quo_q[26]};
  assign trial    = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign q_bit    = ~trial[18];
  assign rem_next = q_bit ? trial[16:0] : rem_sh[16:0];
  assign quo_next = {quo_q[25:0], q_bit};

  assign q_ext   = {3'b000, quo_q};
  assign sum_add = neg_q ? (sum_q - q_ext) : (sum_q + q_ext);

  always_comb begin
    if (!neg_q) begin
      i_sat = (quo_q > tpid_pkg::IntMaxMag) ? tpid_pkg::IntMax : quo_q[15:0];
    end else begin
      i_sat = (quo_q > tpid_pkg::IntMinMag) ? tpid_pkg::IntMin : (16'd0 - quo_q[15:0]);
    end
  end

  assign sum_i    = sum_q + {{14{i_sat[15]}}, i_sat};
  assign diff_err = {e_q[15], e_q} - {last_err_q[15], last_err_q};
  assign gd5      = {1'b0, gain_d_q, 2'b00} + {3'b000, gain_d_q};

  always_comb begin
    if (sum_q[29]) begin
      sum_clamp = 8'd0;
    end else if (sum_q > 30'd255) begin
      sum_clamp = 8'd255;
    end else begin
      sum_clamp = sum_q[7:0];
    end
  end

  assign mul_last = (cnt_q == tpid_pkg::MulLast);
  assign div_last = (cnt_q == tpid_pkg::DivLast);
  assign out_free = ~out_valid_q | ~out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tpid_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = raw_word_i[2] ? tpid_pkg::ST_DONE : tpid_pkg::ST_P_MUL;
        end
      end
      tpid_pkg::ST_P_MUL:  if (mul_last) state_d = tpid_pkg::ST_P_ABS;
      tpid_pkg::ST_P_ABS:  state_d = tpid_pkg::ST_P_DIV;
      tpid_pkg::ST_P_DIV:  if (div_last) state_d = tpid_pkg::ST_P_SUM;
      tpid_pkg::ST_P_SUM:  state_d = tpid_pkg::ST_I_MUL0;
      tpid_pkg::ST_I_MUL0: if (mul_last) state_d = tpid_pkg::ST_I_MUL1;
      tpid_pkg::ST_I_MUL1: if (mul_last) state_d = tpid_pkg::ST_I_ABS;
      tpid_pkg::ST_I_ABS:  state_d = tpid_pkg::ST_I_DIV;
      tpid_pkg::ST_I_DIV:  if (div_last) state_d = tpid_pkg::ST_I_SUM;
      tpid_pkg::ST_I_SUM: begin
        state_d = (ms_q == 16'd0) ? tpid_pkg::ST_DONE : tpid_pkg::ST_D_MUL;
      end
      tpid_pkg::ST_D_MUL:  if (mul_last) state_d = tpid_pkg::ST_D_ABS;
      tpid_pkg::ST_D_ABS:  state_d = tpid_pkg::ST_D_DIV;
      tpid_pkg::ST_D_DIV:  if (div_last) state_d = tpid_pkg::ST_D_SUM;
      tpid_pkg::ST_D_SUM:  state_d = tpid_pkg::ST_DONE;
      tpid_pkg::ST_DONE:   if (out_free) state_d = tpid_pkg::ST_IDLE;
      default:             state_d = tpid_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctl = '0;
    case (state_q)
      tpid_pkg::ST_IDLE: ;
      tpid_pkg::ST_P_MUL, tpid_pkg::ST_I_MUL0, tpid_pkg::ST_I_MUL1, tpid_pkg::ST_D_MUL: begin
        ctl.in_stall = 1'b1;
        ctl.mul_en   = 1'b1;
      end
      tpid_pkg::ST_P_ABS, tpid_pkg::ST_I_ABS, tpid_pkg::ST_D_ABS: begin
        ctl.in_stall = 1'b1;
        ctl.abs_en   = 1'b1;
      end
      tpid_pkg::ST_P_DIV, tpid_pkg::ST_I_DIV, tpid_pkg::ST_D_DIV: begin
        ctl.in_stall = 1'b1;
        ctl.div_en   = 1'b1;
      end
      default: ctl.in_stall = 1'b1;
    endcase
  end

  assign in_stall_o = ctl.in_stall;

  always_comb begin
    if ((ctl.mul_en && !mul_last) || (ctl.div_en && !div_last)) begin
      cnt_d = cnt_q + 5'd1;
    end else begin
      cnt_d = 5'd0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == tpid_pkg::ST_DONE && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpid_pkg::ST_IDLE;
      cnt_q       <= 5'd0;
      out_valid_q <= 1'b0;
      integ_q     <= 16'd0;
      last_err_q  <= 16'd0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (state_q == tpid_pkg::ST_I_SUM) begin
        integ_q <= i_sat;
      end
      if (state_q == tpid_pkg::ST_DONE && out_free && !fault_q) begin
        last_err_q <= e_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.mul_en) begin
      acc_q <= acc_step;
      if (state_q == tpid_pkg::ST_I_MUL0 && mul_last) begin
        mcand_q  <= {{16{e_q[15]}}, e_q};
        mplier_q <= {3'b000, gain_i_q};
      end else begin
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
      end
    end
    if (ctl.abs_en) begin
      neg_q <= acc_q[31];
      quo_q <= acc_mag[26:0];
      rem_q <= 17'd0;
      dvs_q <= (state_q == tpid_pkg::ST_D_ABS) ? {ms_q, 1'b0} : tpid_pkg::GainDivisor;
    end
    if (ctl.div_en) begin
      quo_q <= quo_next;
      rem_q <= rem_next;
    end
    case (state_q)
      tpid_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          e_q      <= e_in;
          temp_q   <= raw_word_i[2] ? 13'd0 : raw_word_i[15:3];
          fault_q  <= raw_word_i[2];
          ms_q     <= elapsed_ms_i;
          acc_q    <= 32'd0;
          mcand_q  <= {{16{e_in[15]}}, e_in};
          mplier_q <= {3'b000, gain_p_q};
          sum_q    <= 30'd0;
        end
      end
      tpid_pkg::ST_P_SUM: begin
        sum_q    <= sum_add;
        acc_q    <= 32'd0;
        mcand_q  <= {{16{integ_q[15]}}, integ_q};
        mplier_q <= tpid_pkg::IntScale;
      end
      tpid_pkg::ST_I_SUM: begin
        sum_q    <= sum_i;
        acc_q    <= 32'd0;
        mcand_q  <= {{15{diff_err[16]}}, diff_err};
        mplier_q <= gd5;
      end
      tpid_pkg::ST_D_SUM: begin
        sum_q <= sum_add;
      end
      tpid_pkg::ST_DONE: begin
        if (out_free) begin
          pwm_duty_q     <= tpid_pkg::DutyOff - sum_clamp;
          sensor_fault_q <= fault_q;
          temp_out_q     <= temp_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o               = out_valid_q;
  assign pwm_duty_o                = pwm_duty_q;
  assign sensor_fault_o            = sensor_fault_q;
  assign temperature_quarter_deg_o = temp_out_q;

endmodule
